// ===== rtl/msrm_pkg.sv =====
package msrm_pkg;

    // register reset values
    localparam logic [31:0] SETTLE_RESET = 32'd1000;
    localparam logic [30:0] WINDOW_RESET = 31'd12000;

    localparam int QUEUE_DEPTH  = 2;
    localparam int SAMPLE_DEPTH = 3;

    // motion event codes
    localparam logic [1:0] EV_ACTIVITY   = 2'd1;
    localparam logic [1:0] EV_INACTIVITY = 2'd2;

    // window end codes
    localparam logic [1:0] END_NONE    = 2'd0;
    localparam logic [1:0] END_CANCEL  = 2'd1;
    localparam logic [1:0] END_TIMEOUT = 2'd2;
    localparam logic [1:0] END_DONE    = 2'd3;

    // configuration register indexes
    localparam int         CFG_IDX_W  = 2;
    localparam logic [1:0] REG_SETTLE = 2'd0;
    localparam logic [1:0] REG_WINDOW = 2'd1;

    // classified item handed from front to back
    typedef struct packed {
        logic [31:0]        now;
        logic               active;
        logic               eligible;
        logic               ev_act;
        logic               ev_inact;
        logic               obs_cand;
        logic [15:0]        msg_id;
        logic signed [7:0]  rssi;
        logic [31:0]        recv;
    } t_item;

    typedef struct packed {
        logic               settled;
        logic               opened;
        logic [1:0]         ended;
        logic               taken;
        logic [1:0]         held;
        logic signed [7:0]  median;
    } t_result;

endpackage

// ===== rtl/motion_settle_rssi_median_core.sv =====
// Movement-settle detector with a peer RSSI median sampler. Each input beat is
// one pass of the host loop: a millisecond timestamp, the local-active and
// peer-offline flags, a motion event and optionally one RSSI observation.
// Every input beat yields exactly one output beat, in order. A movement machine
// (ready, moving, waiting) flags settled once inactivity has lasted
// settle_time_ms; settling opens a sampling window when the device is active
// and the peer online. The window is cancelled by activity or loss of
// eligibility, times out after window_time_ms, or completes when three peer
// observations with distinct message ids have arrived strictly inside it,
// reporting their median RSSI. All time arithmetic wraps modulo 2^32.
// Throughput is one beat per clock while the output is not stalled; an accepted
// beat passes a queue entry, then the output register. The front classifies
// each beat and pushes it into a two-entry queue; the back, unless stalled,
// applies the whole state update for one beat per clock and holds the result
// in an output register, so an output stall is absorbed by the queue before
// the input side stalls. Configuration writes are always ready and must only
// be issued while no beat is in flight.
module motion_settle_rssi_median_core
    import msrm_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH   // front-to-back queue entries, >= 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,

    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_now_ms,
    input  logic                 i_local_active,
    input  logic                 i_peer_offline,
    input  logic [1:0]           i_motion_event,
    input  logic                 i_obs_valid,
    input  logic                 i_obs_from_peer,
    input  logic [15:0]          i_obs_message_id,
    input  logic signed [7:0]    i_obs_rssi,
    input  logic [31:0]          i_obs_received_ms,

    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_settled,
    output logic                 o_window_opened,
    output logic [1:0]           o_window_ended,
    output logic                 o_sample_taken,
    output logic [1:0]           o_samples_held,
    output logic signed [7:0]    o_median_rssi
);

    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_nempty;
    t_item   w_front_item;
    t_item   w_back_item;
    t_result w_result;

    // registers are plain flops; writes never need to wait
    assign o_cfg_ready = 1'b1;

    // front: accept and classify one beat per clock, stall only on a full queue
    msrm_front u_front (
        .i_valid           (i_in_valid),
        .i_full            (w_full),
        .i_now_ms          (i_now_ms),
        .i_local_active    (i_local_active),
        .i_peer_offline    (i_peer_offline),
        .i_motion_event    (i_motion_event),
        .i_obs_valid       (i_obs_valid),
        .i_obs_from_peer   (i_obs_from_peer),
        .i_obs_message_id  (i_obs_message_id),
        .i_obs_rssi        (i_obs_rssi),
        .i_obs_received_ms (i_obs_received_ms),
        .o_stall           (o_in_stall),
        .o_push            (w_push),
        .o_item            (w_front_item)
    );

    // decouples front and back so each side can stall on its own
    msrm_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_front_item),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_nempty (w_nempty),
        .o_item   (w_back_item)
    );

    // back: state machine, sample store, median and output register
    msrm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_nempty    (w_nempty),
        .i_item      (w_back_item),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (w_result)
    );

    assign o_settled       = w_result.settled;
    assign o_window_opened = w_result.opened;
    assign o_window_ended  = w_result.ended;
    assign o_sample_taken  = w_result.taken;
    assign o_samples_held  = w_result.held;
    assign o_median_rssi   = w_result.median;

endmodule

// ===== rtl/msrm_front.sv =====
module msrm_front
    import msrm_pkg::*;
(
    input  logic               i_valid,
    input  logic               i_full,
    input  logic [31:0]        i_now_ms,
    input  logic               i_local_active,
    input  logic               i_peer_offline,
    input  logic [1:0]         i_motion_event,
    input  logic               i_obs_valid,
    input  logic               i_obs_from_peer,
    input  logic [15:0]        i_obs_message_id,
    input  logic signed [7:0]  i_obs_rssi,
    input  logic [31:0]        i_obs_received_ms,
    output logic               o_stall,
    output logic               o_push,
    output t_item              o_item
);

    logic [31:0] w_obs_lag;

    // observation age relative to now; top bit set means captured in the future
    assign w_obs_lag = i_now_ms - i_obs_received_ms;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.now      = i_now_ms;
        o_item.active   = i_local_active;
        o_item.eligible = i_local_active && !i_peer_offline;
        o_item.ev_act   = (i_motion_event == EV_ACTIVITY);
        o_item.ev_inact = (i_motion_event == EV_INACTIVITY);
        o_item.obs_cand = i_obs_valid && i_obs_from_peer && !w_obs_lag[31];
        o_item.msg_id   = i_obs_message_id;
        o_item.rssi     = i_obs_rssi;
        o_item.recv     = i_obs_received_ms;
    end

endmodule

// ===== rtl/msrm_queue.sv =====
module msrm_queue
    import msrm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_nempty,
    output t_item o_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_full   = (r_cnt == CW'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_item   = r_mem[r_rd];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== rtl/msrm_back.sv =====
module msrm_back
    import msrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_nempty,
    input  t_item                i_item,
    output logic                 o_pop,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output t_result              o_out
);

    localparam logic [1:0] PH_READY   = 2'd0;
    localparam logic [1:0] PH_MOVING  = 2'd1;
    localparam logic [1:0] PH_WAITING = 2'd2;

    logic [31:0]        r_settle_time;
    logic [30:0]        r_window_time;

    logic [1:0]         r_phase, n_phase;
    logic [31:0]        r_settle_start, n_settle_start;
    logic               r_window_open, n_window_open;
    logic [31:0]        r_window_start, n_window_start;
    logic [1:0]         r_count, n_count;
    logic [15:0]        r_ids  [SAMPLE_DEPTH];
    logic signed [7:0]  r_lvls [SAMPLE_DEPTH];

    logic               r_out_valid;
    t_result            r_out, n_out;

    logic               w_store;
    logic [1:0]         w_slot;

    function automatic logic signed [7:0] med3(input logic signed [7:0] a,
                                               input logic signed [7:0] b,
                                               input logic signed [7:0] c);
        logic signed [7:0] lo, hi, m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        med3 = (lo > m) ? lo : m;
    endfunction

    assign o_pop       = i_nempty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // one item's full state update: cancel, movement, open, timeout, sample
    always_comb begin
        logic        cancel, wo1, opened, wo2, timeout, wo3, dup, ok, done;
        logic [1:0]  p1;
        logic [31:0] s1, ws2, settle_age, win_age, obs_age;
        logic [1:0]  cnt3;

        n_out = '0;

        cancel = r_window_open && (!i_item.eligible || i_item.ev_act);
        wo1    = r_window_open && !cancel;
        n_out.ended = cancel ? END_CANCEL : END_NONE;

        p1 = r_phase;
        s1 = r_settle_start;
        if (i_item.ev_act) begin
            p1 = PH_MOVING;
            s1 = '0;
        end else if (i_item.ev_inact && r_phase == PH_MOVING) begin
            p1 = PH_WAITING;
            s1 = i_item.now;
        end
        settle_age = i_item.now - s1;
        n_out.settled = i_item.active && (p1 == PH_WAITING) &&
                        (settle_age >= r_settle_time);
        if (!i_item.active || n_out.settled) begin
            n_phase        = PH_READY;
            n_settle_start = '0;
        end else begin
            n_phase        = p1;
            n_settle_start = s1;
        end

        opened = n_out.settled && !wo1 && i_item.eligible;
        n_out.opened = opened;
        wo2 = wo1 || opened;
        ws2 = opened ? i_item.now : r_window_start;

        win_age = i_item.now - ws2;
        timeout = wo2 && (win_age >= {1'b0, r_window_time});
        wo3     = wo2 && !timeout;
        if (timeout) begin
            n_out.ended = END_TIMEOUT;
        end

        cnt3 = (cancel || opened || timeout) ? 2'd0 : r_count;

        dup = 1'b0;
        for (int i = 0; i < SAMPLE_DEPTH; i++) begin
            if (2'(i) < cnt3 && r_ids[i] == i_item.msg_id) begin
                dup = 1'b1;
            end
        end
        obs_age = i_item.recv - ws2;
        ok   = i_item.obs_cand && wo3 && (obs_age != '0) &&
               (obs_age < {1'b0, r_window_time}) && !dup;
        done = ok && (cnt3 == 2'(SAMPLE_DEPTH - 1));

        n_out.taken = ok;
        n_out.held  = ok ? cnt3 + 2'd1 : cnt3;
        if (done) begin
            n_out.ended  = END_DONE;
            n_out.median = med3(r_lvls[0], r_lvls[1], i_item.rssi);
        end

        n_window_open  = wo3 && !done;
        n_window_start = ws2;
        n_count        = (done || !wo3) ? 2'd0 : n_out.held;

        w_store = ok && !done;
        w_slot  = cnt3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_time  <= SETTLE_RESET;
            r_window_time  <= WINDOW_RESET;
            r_phase        <= PH_READY;
            r_settle_start <= '0;
            r_window_open  <= 1'b0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SETTLE: r_settle_time <= i_cfg_data;
                    REG_WINDOW: r_window_time <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (o_pop) begin
                r_phase        <= n_phase;
                r_settle_start <= n_settle_start;
                r_window_open  <= n_window_open;
                r_count        <= n_count;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_window_start <= n_window_start;
            r_out          <= n_out;
            if (w_store) begin
                r_ids[w_slot]  <= i_item.msg_id;
                r_lvls[w_slot] <= i_item.rssi;
            end
        end
    end

`ifndef SYNTHESIS
    a_done_holds_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.ended == END_DONE |-> r_out.held == 2'd3 && r_out.taken)
        else $error("completed window without three samples");

    a_count_below_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("sample count reached depth without completing");

    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_window_open |-> r_count == 2'd0)
        else $error("samples held while window closed");

    a_start_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_WAITING |-> r_settle_start == '0)
        else $error("settle start set outside waiting phase");
`endif

endmodule

// ===== test/settle_median_checker.sv =====
`timescale 1ns / 1ps

// Watches the config, input and result channels, tracks the block's state on
// every accepted input beat and compares each result beat in order.
module settle_median_checker
    import msrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,

    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [31:0]          i_now_ms,
    input  logic                 i_local_active,
    input  logic                 i_peer_offline,
    input  logic [1:0]           i_motion_event,
    input  logic                 i_obs_valid,
    input  logic                 i_obs_from_peer,
    input  logic [15:0]          i_obs_message_id,
    input  logic signed [7:0]    i_obs_rssi,
    input  logic [31:0]          i_obs_received_ms,

    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_settled,
    input  logic                 i_window_opened,
    input  logic [1:0]           i_window_ended,
    input  logic                 i_sample_taken,
    input  logic [1:0]           i_samples_held,
    input  logic signed [7:0]    i_median_rssi,

    output int                   o_fail_count,
    output int                   o_pending
);

    typedef enum logic [1:0] {
        PH_READY   = 2'd0,
        PH_MOVING  = 2'd1,
        PH_WAITING = 2'd2
    } t_phase;

    logic [31:0]       settle_len;
    logic [30:0]       window_ms;
    t_phase            phase;
    logic [31:0]       settle_mark;
    logic              win_open;
    logic [31:0]       win_mark;
    logic [1:0]        n_held;
    logic [15:0]       held_ids [SAMPLE_DEPTH];
    logic signed [7:0] held_levels [SAMPLE_DEPTH];

    t_result           due_reports [$];
    int                mismatches;

    assign o_fail_count = mismatches;

    function automatic logic signed [7:0] middle_of(input logic signed [7:0] a,
                                                    input logic signed [7:0] b,
                                                    input logic signed [7:0] c);
        logic signed [7:0] t;
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
        return b;
    endfunction

    task automatic drop_window();
        win_open = 1'b0;
        win_mark = '0;
        n_held   = '0;
        for (int k = 0; k < SAMPLE_DEPTH; k++) begin
            held_ids[k]    = '0;
            held_levels[k] = '0;
        end
    endtask

    // One loop pass: cancel, movement machine, open, timeout, then the sample.
    task automatic run_loop_pass(input logic [31:0] now, input logic active,
                                 input logic offline, input logic [1:0] ev,
                                 input logic ov, input logic peer,
                                 input logic [15:0] id, input logic signed [7:0] rssi,
                                 input logic [31:0] recv, output t_result r);
        logic [31:0] after;
        logic [31:0] lag;
        logic        fresh;
        r = '0;
        if (win_open && (!active || offline)) begin
            drop_window();
            r.ended = END_CANCEL;
        end
        if (ev == EV_ACTIVITY && win_open) begin
            drop_window();
            r.ended = END_CANCEL;
        end

        if (!active) begin
            phase       = PH_READY;
            settle_mark = '0;
        end else begin
            if (ev == EV_ACTIVITY) begin
                phase       = PH_MOVING;
                settle_mark = '0;
            end else if (ev == EV_INACTIVITY && phase == PH_MOVING) begin
                phase       = PH_WAITING;
                settle_mark = now;
            end
            if (phase == PH_WAITING && (now - settle_mark) >= settle_len) begin
                phase       = PH_READY;
                settle_mark = '0;
                r.settled   = 1'b1;
            end
        end

        if (r.settled && !win_open && active && !offline) begin
            drop_window();
            win_open = 1'b1;
            win_mark = now;
            r.opened = 1'b1;
        end
        if (win_open && (now - win_mark) >= {1'b0, window_ms}) begin
            drop_window();
            r.ended = END_TIMEOUT;
        end

        r.held = n_held;
        if (ov && win_open && peer) begin
            after = recv - win_mark;
            lag   = now - recv;
            fresh = after != '0 && after < {1'b0, window_ms} && !lag[31];
            for (int k = 0; k < n_held; k++)
                if (held_ids[k] == id)
                    fresh = 1'b0;
            if (fresh && n_held < SAMPLE_DEPTH) begin
                held_ids[n_held]    = id;
                held_levels[n_held] = rssi;
                n_held  = n_held + 1'b1;
                r.taken = 1'b1;
                r.held  = n_held;
                if (n_held == SAMPLE_DEPTH) begin
                    r.median = middle_of(held_levels[0], held_levels[1], held_levels[2]);
                    r.ended  = END_DONE;
                    drop_window();
                end
            end
        end
    endtask

    task automatic check_field(input string tag, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 200)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            settle_len  = SETTLE_RESET;
            window_ms   = WINDOW_RESET;
            phase       = PH_READY;
            settle_mark = '0;
            drop_window();
            due_reports.delete();
            mismatches  = 0;
            o_pending  <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SETTLE: settle_len = i_cfg_data;
                    REG_WINDOW: window_ms  = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            // pop before push: a beat accepted now cannot leave in the same cycle
            if (i_out_valid && !i_out_stall) begin
                if (due_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat, expected none pending, got ended=%0d held=%0d",
                             $time, i_window_ended, i_samples_held);
                end else begin
                    want = due_reports.pop_front();
                    check_field("settled", want.settled, i_settled);
                    check_field("window_opened", want.opened, i_window_opened);
                    check_field("window_ended", want.ended, i_window_ended);
                    check_field("sample_taken", want.taken, i_sample_taken);
                    check_field("samples_held", want.held, i_samples_held);
                    check_field("median_rssi", want.median, i_median_rssi);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                run_loop_pass(i_now_ms, i_local_active, i_peer_offline, i_motion_event,
                              i_obs_valid, i_obs_from_peer, i_obs_message_id, i_obs_rssi,
                              i_obs_received_ms, want);
                due_reports.push_back(want);
            end
            o_pending <= due_reports.size();
        end
    end

endmodule

// ===== test/tb_motion_settle_rssi_median_core.sv =====
`timescale 1ns / 1ps

module tb_motion_settle_rssi_median_core;
    import msrm_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_RESERVED = 2'd3;  // behaves as no event
    localparam logic [1:0] REG_SPARE_A = 2'd2;  // unmapped register slots
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    localparam int ITEM_TARGET = 1050;
    localparam int PHASES      = 8;
    localparam int STALL_LIMIT = 2000;  // cycles with no beat on any channel

    // one loop pass as driven on the input channel
    typedef struct packed {
        logic [31:0]       now;
        logic              active;
        logic              offline;
        logic [1:0]        ev;
        logic              ov;
        logic              peer;
        logic [15:0]       id;
        logic signed [7:0] rssi;
        logic [31:0]       recv;
    } t_pass;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_SETTLE;
    logic [31:0]          i_cfg_data = '0;
    logic                 o_cfg_ready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [31:0]          i_now_ms = '0;
    logic                 i_local_active = 1'b0;
    logic                 i_peer_offline = 1'b0;
    logic [1:0]           i_motion_event = EV_NONE;
    logic                 i_obs_valid = 1'b0;
    logic                 i_obs_from_peer = 1'b0;
    logic [15:0]          i_obs_message_id = '0;
    logic signed [7:0]    i_obs_rssi = '0;
    logic [31:0]          i_obs_received_ms = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_settled;
    logic                 o_window_opened;
    logic [1:0]           o_window_ended;
    logic                 o_sample_taken;
    logic [1:0]           o_samples_held;
    logic signed [7:0]    o_median_rssi;

    int          fail_count;
    int          pending;
    int          sent = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;      // this session sends back to back
    bit          pressing = 1'b0;  // long output hold in progress: no gaps
    bit          hold_req = 1'b0;
    bit          hold_active = 1'b0;
    bit          hold_done = 1'b0;
    logic [31:0] clock_ms = '0;
    logic [31:0] settle_cur = SETTLE_RESET;
    logic [31:0] window_cur = {1'b0, WINDOW_RESET};

    motion_settle_rssi_median_core u_top (.*);

    settle_median_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_now_ms         (i_now_ms),
        .i_local_active   (i_local_active),
        .i_peer_offline   (i_peer_offline),
        .i_motion_event   (i_motion_event),
        .i_obs_valid      (i_obs_valid),
        .i_obs_from_peer  (i_obs_from_peer),
        .i_obs_message_id (i_obs_message_id),
        .i_obs_rssi       (i_obs_rssi),
        .i_obs_received_ms(i_obs_received_ms),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_settled        (o_settled),
        .i_window_opened  (o_window_opened),
        .i_window_ended   (o_window_ended),
        .i_sample_taken   (o_sample_taken),
        .i_samples_held   (o_samples_held),
        .i_median_rssi    (o_median_rssi),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_pass pass_of(input logic [31:0] now, input logic active,
                                      input logic offline, input logic [1:0] ev,
                                      input logic ov, input logic peer,
                                      input logic [15:0] id, input logic [7:0] rssi,
                                      input logic [31:0] recv);
        return {now, active, offline, ev, ov, peer, id, rssi, recv};
    endfunction

    // active, online, no event, no observation; the ignored fields still toggle
    function automatic t_pass quiet(input logic [31:0] now);
        return pass_of(now, 1'b1, 1'b0, EV_NONE, 1'b0, 1'($urandom), 16'($urandom),
                       8'($urandom), $urandom);
    endfunction

    // Offer one beat after an optional gap and hold it until it is taken.
    // Valid stays high on return so back-to-back beats need no deassertion.
    task automatic send_pass(input t_pass p);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(6, 30);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_now_ms          <= p.now;
        i_local_active    <= p.active;
        i_peer_offline    <= p.offline;
        i_motion_event    <= p.ev;
        i_obs_valid       <= p.ov;
        i_obs_from_peer   <= p.peer;
        i_obs_message_id  <= p.id;
        i_obs_rssi        <= p.rssi;
        i_obs_received_ms <= p.recv;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    // Stop offering, let every result beat out, then let the two-stage
    // pipe sit idle before anything touches the registers.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // settle time, a write to an unmapped slot, then window length
    task automatic write_settings(input logic [31:0] settle, input logic [31:0] window,
                                  input logic [1:0] spare_idx);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_SETTLE;
        i_cfg_data  <= settle;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= spare_idx;
        i_cfg_data  <= $urandom;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_WINDOW;
        i_cfg_data  <= window;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settle_cur = settle;
        window_cur = window & 32'h7FFF_FFFF;
    endtask

    // Hand-picked walk through the reset settings (settle 1000, window 12000).
    task automatic directed_passes();
        send_pass(pass_of(32'd0, 1, 0, EV_ACTIVITY, 0, 0, 16'h0000, 8'h00, 32'd0));
        send_pass(pass_of(32'd10, 1, 0, EV_INACTIVITY, 0, 1, 16'hFFFF, 8'h7F, 32'hFFFF_FFFF));
        // repeated inactivity must not restart the settle timer
        send_pass(pass_of(32'd500, 1, 0, EV_INACTIVITY, 0, 0, 16'h0000, 8'h00, 32'd0));
        // reserved event code, settles and opens; sample at the window start is refused
        send_pass(pass_of(32'd1010, 1, 0, EV_RESERVED, 1, 1, 16'h0001, 8'h10, 32'd1010));
        send_pass(pass_of(32'd1020, 1, 0, EV_NONE, 1, 1, 16'h0000, 8'h80, 32'd1015));
        // duplicate id, foreign sender, capture in the future
        send_pass(pass_of(32'd1030, 1, 0, EV_NONE, 1, 1, 16'h0000, 8'h00, 32'd1025));
        send_pass(pass_of(32'd1040, 1, 0, EV_NONE, 1, 0, 16'h0005, 8'h00, 32'd1035));
        send_pass(pass_of(32'd1050, 1, 0, EV_NONE, 1, 1, 16'hFFFF, 8'h7F, 32'd1051));
        send_pass(pass_of(32'd1070, 1, 0, EV_NONE, 1, 1, 16'hFFFF, 8'h7F, 32'd1065));
        // third distinct sample completes the window with the median
        send_pass(pass_of(32'd1080, 1, 0, EV_NONE, 1, 1, 16'h0007, 8'h05, 32'd1080));
        // settle while the peer is offline: no window
        send_pass(pass_of(32'd1100, 1, 0, EV_ACTIVITY, 0, 0, 16'h0000, 8'h00, 32'd0));
        send_pass(pass_of(32'd1100, 1, 0, EV_INACTIVITY, 0, 0, 16'h0000, 8'h00, 32'd0));
        send_pass(pass_of(32'd2100, 1, 1, EV_NONE, 0, 0, 16'h0000, 8'h00, 32'd0));
        // open, then cancel by activity
        send_pass(pass_of(32'd2200, 1, 0, EV_ACTIVITY, 0, 0, 16'h0000, 8'h00, 32'd0));
        send_pass(pass_of(32'd2200, 1, 0, EV_INACTIVITY, 0, 0, 16'h0000, 8'h00, 32'd0));
        send_pass(pass_of(32'd3200, 1, 0, EV_NONE, 0, 0, 16'h0000, 8'h00, 32'd0));
        send_pass(pass_of(32'd3300, 1, 0, EV_ACTIVITY, 0, 0, 16'h0000, 8'h00, 32'd0));
        // open, then cancel by going inactive
        send_pass(pass_of(32'd3300, 1, 0, EV_INACTIVITY, 0, 0, 16'h0000, 8'h00, 32'd0));
        send_pass(pass_of(32'd4300, 1, 0, EV_NONE, 0, 0, 16'h0000, 8'h00, 32'd0));
        send_pass(pass_of(32'd4400, 0, 0, EV_NONE, 0, 0, 16'h0000, 8'h00, 32'd0));
        // open, then time out; the sample on the timeout pass is refused
        send_pass(pass_of(32'd4400, 1, 0, EV_ACTIVITY, 0, 0, 16'h0000, 8'h00, 32'd0));
        send_pass(pass_of(32'd4400, 1, 0, EV_INACTIVITY, 0, 0, 16'h0000, 8'h00, 32'd0));
        send_pass(pass_of(32'd5400, 1, 0, EV_NONE, 0, 0, 16'h0000, 8'h00, 32'd0));
        send_pass(pass_of(32'd17400, 1, 0, EV_NONE, 1, 1, 16'h0003, 8'h01, 32'd17399));
        send_pass(pass_of(32'hFFFF_FFFF, 1, 0, EV_INACTIVITY, 1, 1, 16'hFFFF, 8'hFF,
                          32'hFFFF_FFFF));
    endtask

    // Well-formed sequence: activity, inactivity, settle, then a window's worth
    // of observations with a small id pool so duplicates show up. A little
    // noise is sprinkled in to cancel windows and break sequences.
    task automatic settle_session();
        t_pass       p;
        logic [31:0] inact_at;
        logic [31:0] win_at;
        logic [31:0] span;
        logic [15:0] id_base;
        int          n;
        int          r;
        int          step;
        calm    = pressing || ($urandom_range(0, 4) == 0);
        id_base = 16'($urandom);
        step    = (window_cur > 32'd200) ? 40 : int'(window_cur >> 2) + 1;

        p = quiet(clock_ms);
        p.ev = EV_ACTIVITY;
        if ($urandom_range(0, 9) == 0) p.ov = 1'b1;
        send_pass(p);
        clock_ms += $urandom_range(0, 5);
        p = quiet(clock_ms);
        p.ev = EV_INACTIVITY;
        send_pass(p);
        inact_at = clock_ms;
        win_at   = clock_ms;
        if ($urandom_range(0, 2) == 0) begin
            clock_ms += $urandom_range(0, 3);
            p = quiet(clock_ms);
            p.ev = EV_INACTIVITY;
            send_pass(p);
        end

        // zero settle time already fired on the inactivity pass
        if (settle_cur != 0) begin
            if ($urandom_range(0, 2) == 0)
                send_pass(quiet(inact_at + (settle_cur >> 1)));
            clock_ms = inact_at + settle_cur;
            if (settle_cur < 32'hFFFF_FF00) clock_ms += $urandom_range(0, 2);
            win_at = clock_ms;
            p = quiet(clock_ms);
            r = $urandom_range(0, 19);
            if (r == 0)
                p.offline = 1'b1;
            else if (r == 1)
                p.active = 1'b0;
            send_pass(p);
        end

        n = $urandom_range(3, 8);
        repeat (n) begin
            if ($urandom_range(0, 99) < 6)
                clock_ms = win_at + window_cur + $urandom_range(0, 1);
            else
                clock_ms += $urandom_range(1, step);
            p = quiet(clock_ms);
            p.ov   = ($urandom_range(0, 9) != 0);
            p.peer = ($urandom_range(0, 11) != 0);
            p.id   = id_base + 16'($urandom_range(0, 4));
            span   = clock_ms - win_at;
            r = $urandom_range(0, 99);
            if (r < 72 && span != 0)
                p.recv = win_at + $urandom_range(1, span);
            else if (r < 80)
                p.recv = win_at;
            else if (r < 88)
                p.recv = clock_ms + $urandom_range(1, 9);
            else if (r < 94)
                p.recv = win_at + window_cur;
            else
                p.recv = $urandom;
            r = $urandom_range(0, 99);
            if (r < 2)
                p.active = 1'b0;
            else if (r < 4)
                p.offline = 1'b1;
            else if (r < 6)
                p.ev = EV_ACTIVITY;
            else if (r < 9)
                p.ev = EV_RESERVED;
            else if (r < 11)
                p.ev = EV_INACTIVITY;
            send_pass(p);
        end
    endtask

    // a few passes with every field random
    task automatic noise_burst();
        t_pass p;
        calm = pressing;
        repeat ($urandom_range(1, 4)) begin
            p = pass_of(($urandom_range(0, 2) == 0) ? $urandom : clock_ms + $urandom_range(0, 50),
                        1'($urandom), 1'($urandom), 2'($urandom_range(0, 3)),
                        1'($urandom), 1'($urandom), 16'($urandom), 8'($urandom),
                        $urandom);
            send_pass(p);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int          ph;
        int          phase_end;
        int          burst_end;
        logic [31:0] s_set;
        logic [31:0] w_set;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_passes();

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: begin s_set = 32'd20;        w_set = 32'd200;        end
                1: begin s_set = 32'd0;         w_set = 32'd1;          end
                2: begin s_set = 32'hFFFF_FFFF; w_set = 32'hFFFF_FFFF;  end
                3: begin s_set = 32'd7;         w_set = 32'd0;          end
                4: begin s_set = 32'd3;         w_set = 32'd60;         end
                default: begin
                    s_set = $urandom_range(0, 120);
                    w_set = $urandom_range(1, 600);
                end
            endcase
            write_settings(s_set, w_set, ph[0] ? REG_SPARE_B : REG_SPARE_A);

            if (ph == 4) begin
                // start near the wrap and let the output side sit on a long hold
                // while beats keep coming, so the queue fills and input stalls
                clock_ms = 32'hFFFF_FF00;
                hold_req <= 1'b1;
                do @(posedge i_clk); while (!hold_active);
                pressing  = 1'b1;
                burst_end = sent + 30;
                while (sent < burst_end) settle_session();
                pressing  = 1'b0;
            end else begin
                clock_ms = $urandom;
            end

            phase_end = 25 + (ph + 1) * (ITEM_TARGET - 25) / PHASES;
            while (sent < phase_end) begin
                if ($urandom_range(0, 99) < 15)
                    noise_burst();
                else
                    settle_session();
            end
        end

        drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Output side: random stall, short mostly, some long, with quiet stretches,
    // plus one long hold on request.
    initial begin
        int quiet_left;
        int r;
        quiet_left = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_active = 1'b1;
                i_out_stall <= 1'b1;
                repeat (80) @(posedge i_clk);
                hold_active = 1'b0;
                hold_done   = 1'b1;
            end else if (quiet_left > 0) begin
                i_out_stall <= 1'b0;
                quiet_left--;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    quiet_left = $urandom_range(30, 150);
                end else if (r < 55) begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
                end else if (r < 92) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: any beat on any channel resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
